// ===== rtl/mmib_pkg.sv =====
// Shared types and constants for the min-max interval binning block.
// Holds the controller command codes, the datapath status bundle and register indexes.
// No dependencies.
package mmib_pkg;

   localparam int BIN_W  = 6;
   localparam int TOL_W  = 12;
   localparam int GIDX_W = 5;

   // configuration register indexes
   localparam logic CSR_BIN_COUNT = 1'b0;
   localparam logic CSR_TIE_TOL   = 1'b1;

   // one command per controller step
   typedef enum logic [4:0] {
      CMD_IDLE, CMD_RANK_LOAD, CMD_RANK_CMP, CMD_RANK_WR, CMD_SRCH_A, CMD_SRCH_B,
      CMD_PAIR_A, CMD_PAIR_B, CMD_GRD_INIT, CMD_GRD_SCAN, CMD_PAIR_NEXT,
      CMD_ST_INIT, CMD_ST_SCAN, CMD_SPL_CHK, CMD_SPL_A, CMD_SPL_B,
      CMD_CEN_INIT, CMD_CEN_SCAN, CMD_WST_INIT, CMD_WST_SCAN, CMD_EMIT
   } cmd_type;

   // datapath status back to the controller
   typedef struct packed {
      logic h_last;
      logic g_last;
      logic npos_zero;
      logic c_less;
      logic k_end;
      logic fits;
      logic pair_done;
      logic j_last;
      logic ns_full;
      logic j_zero;
      logic split_ok;
   } status_type;

endpackage

// ===== rtl/mmib_ctrl.sv =====
// Sequencing controller for the min-max interval binning block.
// Walks rank, width search, bin start, split, centre, mismatch and emit phases.
// Depends on mmib_pkg.
module mmib_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                acc,
   input  logic                req_last,
   input  mmib_pkg::status_type status,
   output mmib_pkg::cmd_type   cmd,
   output logic                busy
);
   import mmib_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_RANK_LOAD, S_RANK_CMP, S_RANK_WR, S_SRCH_A, S_SRCH_B,
      S_PAIR_A, S_PAIR_B, S_GRD_INIT, S_GRD_SCAN, S_PAIR_NEXT,
      S_ST_INIT, S_ST_SCAN, S_SPL_CHK, S_SPL_A, S_SPL_B,
      S_CEN_INIT, S_CEN_SCAN, S_WST_INIT, S_WST_SCAN, S_EMIT
   } state_type;

   state_type state_ff;

   // advance the sequence
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE:      if (acc && req_last) state_ff <= S_RANK_LOAD;
            S_RANK_LOAD: state_ff <= S_RANK_CMP;
            S_RANK_CMP:  if (status.h_last) state_ff <= S_RANK_WR;
            S_RANK_WR:   state_ff <= status.g_last ? S_SRCH_A : S_RANK_LOAD;
            S_SRCH_A:    state_ff <= status.npos_zero ? S_EMIT : S_SRCH_B;
            S_SRCH_B:    state_ff <= S_PAIR_A;
            S_PAIR_A:    state_ff <= S_PAIR_B;
            S_PAIR_B:    state_ff <= status.c_less ? S_GRD_INIT : S_PAIR_NEXT;
            S_GRD_INIT:  state_ff <= S_GRD_SCAN;
            S_GRD_SCAN:  if (status.k_end) state_ff <= S_PAIR_NEXT;
            S_PAIR_NEXT: state_ff <= status.pair_done ? S_ST_INIT : S_PAIR_A;
            S_ST_INIT:   state_ff <= S_ST_SCAN;
            S_ST_SCAN:   if (status.k_end) state_ff <= S_SPL_CHK;
            S_SPL_CHK:   state_ff <= status.ns_full ? S_CEN_INIT : S_SPL_A;
            S_SPL_A:     state_ff <= status.j_zero ? S_CEN_INIT : S_SPL_B;
            S_SPL_B:     state_ff <= status.split_ok ? S_SPL_CHK : S_SPL_A;
            S_CEN_INIT:  state_ff <= S_CEN_SCAN;
            S_CEN_SCAN:  if (status.k_end) state_ff <= S_WST_INIT;
            S_WST_INIT:  state_ff <= S_WST_SCAN;
            S_WST_SCAN:  if (status.k_end) state_ff <= S_EMIT;
            S_EMIT:      if (status.g_last) state_ff <= S_IDLE;
            default:     state_ff <= S_IDLE;
         endcase
      end
   end

   // map state to datapath command
   always_comb begin
      case (state_ff)
         S_RANK_LOAD: cmd = CMD_RANK_LOAD;
         S_RANK_CMP:  cmd = CMD_RANK_CMP;
         S_RANK_WR:   cmd = CMD_RANK_WR;
         S_SRCH_A:    cmd = CMD_SRCH_A;
         S_SRCH_B:    cmd = CMD_SRCH_B;
         S_PAIR_A:    cmd = CMD_PAIR_A;
         S_PAIR_B:    cmd = CMD_PAIR_B;
         S_GRD_INIT:  cmd = CMD_GRD_INIT;
         S_GRD_SCAN:  cmd = CMD_GRD_SCAN;
         S_PAIR_NEXT: cmd = CMD_PAIR_NEXT;
         S_ST_INIT:   cmd = CMD_ST_INIT;
         S_ST_SCAN:   cmd = CMD_ST_SCAN;
         S_SPL_CHK:   cmd = CMD_SPL_CHK;
         S_SPL_A:     cmd = CMD_SPL_A;
         S_SPL_B:     cmd = CMD_SPL_B;
         S_CEN_INIT:  cmd = CMD_CEN_INIT;
         S_CEN_SCAN:  cmd = CMD_CEN_SCAN;
         S_WST_INIT:  cmd = CMD_WST_INIT;
         S_WST_SCAN:  cmd = CMD_WST_SCAN;
         S_EMIT:      cmd = CMD_EMIT;
         default:     cmd = CMD_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (acc && req_last) |=> (state_ff == S_RANK_LOAD))
      else $error("last beat did not start the run");
   a_split_rechecks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SPL_B && status.split_ok) |=> (state_ff == S_SPL_CHK))
      else $error("split did not return to bin count check");
   a_greedy_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GRD_SCAN && !status.k_end) |=> (state_ff == S_GRD_SCAN))
      else $error("greedy pass left early");
endmodule

// ===== rtl/mmib_datapath.sv =====
// Datapath for the min-max interval binning block: stores, counters, one sorted-value
// read port, the greedy width test, centre and mismatch arithmetic, result registers.
// Depends on mmib_pkg.
module mmib_datapath #(
   parameter int MAX_GROUPS = 32,
   parameter int VALUE_BITS = 22
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mmib_pkg::cmd_type                 cmd,
   output mmib_pkg::status_type              status,
   input  logic                              acc,
   input  logic signed [VALUE_BITS-1:0]      req_log_alpha,
   input  logic                              req_no_removal,
   input  logic                              req_last,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [mmib_pkg::TOL_W-1:0]        csr_wdata,
   output logic                              rsp_valid,
   output logic [mmib_pkg::GIDX_W-1:0]       rsp_group_index,
   output logic [mmib_pkg::BIN_W-1:0]        rsp_bin_index,
   output logic signed [VALUE_BITS-1:0]      rsp_bin_log_center,
   output logic                              rsp_unshifted,
   output logic [VALUE_BITS-1:0]             rsp_worst_log_mismatch,
   output logic [mmib_pkg::BIN_W-1:0]        rsp_bins_used,
   output logic                              rsp_final_res
);
   import mmib_pkg::*;

   localparam int IW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int CW  = $clog2(MAX_GROUPS + 1);
   localparam int NBW = (CW > BIN_W) ? CW : BIN_W;
   localparam int DW  = VALUE_BITS + 1;
   localparam int LW  = VALUE_BITS + 2;

   logic signed [VALUE_BITS-1:0] vstore_ff [MAX_GROUPS];
   logic                         fstore_ff [MAX_GROUPS];
   logic signed [VALUE_BITS-1:0] srt_ff    [MAX_GROUPS];
   logic [IW-1:0]                ord_ff    [MAX_GROUPS];
   logic [CW-1:0]                gbin_ff   [MAX_GROUPS];
   logic signed [VALUE_BITS-1:0] center_ff [MAX_GROUPS];
   logic [MAX_GROUPS-1:0]        mask_ff;

   logic [CW-1:0] cnt_ff, n_ff, npos_ff, ns_ff, k_ff, b_ff, bins_ff;
   logic [IW-1:0] g_ff, h_ff, i_ff, j_ff, rank_ff;
   logic signed [VALUE_BITS-1:0] vg_ff, a_ff, start_ff, lo_ff;
   logic                         fg_ff;
   logic signed [DW-1:0]         spread_ff, c_ff;
   logic signed [LW-1:0]         limit_ff;
   logic [VALUE_BITS-1:0]        worst_ff;
   logic [BIN_W-1:0]             bc_ff;
   logic [TOL_W-1:0]             tol_ff;

   logic [IW-1:0]                rd_addr;
   logic signed [VALUE_BITS-1:0] rd;
   logic [IW-1:0]                k_idx, kn_idx;
   logic [BIN_W-1:0]             bc_eff;
   logic [NBW-1:0]               nb;
   logic signed [DW-1:0]         tol_s, grd_diff, c_now, sdiff, wd, wabs;
   logic                         over, rank_less, is_start, blast;
   logic signed [VALUE_BITS-1:0] vh, lo_eff, cval, cen_w;
   logic signed [VALUE_BITS:0]   csum;
   logic [CW-1:0]                cur_b, gb_e;
   logic                         un_e;

   // pick the sorted-value read address for this step
   always_comb begin
      case (cmd)
         CMD_SRCH_B:                             rd_addr = IW'(npos_ff - CW'(1));
         CMD_PAIR_A:                             rd_addr = i_ff;
         CMD_PAIR_B, CMD_SPL_A:                  rd_addr = j_ff;
         CMD_SPL_B:                              rd_addr = j_ff - IW'(1);
         CMD_GRD_SCAN, CMD_ST_SCAN,
         CMD_CEN_SCAN, CMD_WST_SCAN:             rd_addr = k_ff[IW-1:0];
         default:                                rd_addr = '0;
      endcase
   end
   assign rd = srt_ff[rd_addr];

   // effective bin count, clamped to the ratio groups
   assign bc_eff = (bc_ff == '0) ? BIN_W'(1) : bc_ff;
   assign nb = (NBW'(bc_eff) > NBW'(npos_ff)) ? NBW'(npos_ff) : NBW'(bc_eff);

   assign tol_s    = DW'(signed'({1'b0, tol_ff}));
   assign grd_diff = DW'(rd) - DW'(start_ff);
   assign over     = LW'(grd_diff) > limit_ff;
   assign c_now    = DW'(rd) - DW'(a_ff);
   assign sdiff    = DW'(a_ff) - DW'(rd);

   // stable rank compare against the latched group
   assign vh = vstore_ff[h_ff];
   assign rank_less = !fstore_ff[h_ff] && ((vh < vg_ff) || ((vh == vg_ff) && (h_ff < g_ff)));

   // bin centre step
   assign k_idx    = k_ff[IW-1:0];
   assign kn_idx   = k_idx + IW'(1);
   assign is_start = mask_ff[k_idx];
   assign lo_eff   = is_start ? rd : lo_ff;
   assign blast    = (k_ff == npos_ff - CW'(1)) || mask_ff[kn_idx];
   assign csum     = (VALUE_BITS+1)'(lo_eff) + (VALUE_BITS+1)'(rd);
   assign cval     = VALUE_BITS'(csum >>> 1);

   // mismatch step
   assign cur_b = (is_start && k_ff != '0) ? b_ff + CW'(1) : b_ff;
   assign cen_w = center_ff[cur_b[IW-1:0]];
   assign wd    = DW'(rd) - DW'(cen_w);
   assign wabs  = (wd < 0) ? -wd : wd;

   assign un_e = fstore_ff[g_ff];
   assign gb_e = gbin_ff[g_ff];

   // status back to the controller
   always_comb begin
      status.h_last    = (CW'(h_ff) == n_ff - CW'(1));
      status.g_last    = (CW'(g_ff) == n_ff - CW'(1));
      status.npos_zero = (npos_ff == '0);
      status.c_less    = (c_now < spread_ff);
      status.k_end     = (k_ff == npos_ff);
      status.fits      = (NBW'(bins_ff) <= nb);
      status.j_last    = (CW'(j_ff) == npos_ff - CW'(1));
      status.pair_done = status.j_last && (CW'(i_ff) == npos_ff - CW'(1));
      status.ns_full   = (NBW'(ns_ff) >= nb);
      status.j_zero    = (j_ff == '0);
      status.split_ok  = !mask_ff[j_ff] && (sdiff > tol_s);
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bc_ff  <= BIN_W'(1);
         tol_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BIN_COUNT: bc_ff  <= csr_wdata[BIN_W-1:0];
            CSR_TIE_TOL:   tol_ff <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // load counter and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= (cmd == CMD_EMIT);
         if (cmd == CMD_IDLE && acc) begin
            if (req_last)
               cnt_ff <= '0;
            else if (cnt_ff < CW'(MAX_GROUPS))
               cnt_ff <= cnt_ff + CW'(1);
         end
      end
   end

   // execute one step of the command
   always_ff @(posedge clock) begin
      case (cmd)
         CMD_IDLE: begin
            if (acc) begin
               if (cnt_ff < CW'(MAX_GROUPS)) begin
                  vstore_ff[cnt_ff[IW-1:0]] <= req_log_alpha;
                  fstore_ff[cnt_ff[IW-1:0]] <= req_no_removal;
               end
               if (req_last) begin
                  n_ff     <= (cnt_ff < CW'(MAX_GROUPS)) ? cnt_ff + CW'(1) : cnt_ff;
                  g_ff     <= '0;
                  npos_ff  <= '0;
                  ns_ff    <= '0;
                  worst_ff <= '0;
                  mask_ff  <= '0;
               end
            end
         end
         CMD_RANK_LOAD: begin
            vg_ff   <= vstore_ff[g_ff];
            fg_ff   <= fstore_ff[g_ff];
            h_ff    <= '0;
            rank_ff <= '0;
         end
         CMD_RANK_CMP: begin
            if (rank_less) rank_ff <= rank_ff + IW'(1);
            h_ff <= h_ff + IW'(1);
         end
         CMD_RANK_WR: begin
            if (!fg_ff) begin
               srt_ff[rank_ff] <= vg_ff;
               ord_ff[rank_ff] <= g_ff;
               npos_ff         <= npos_ff + CW'(1);
            end
            g_ff <= status.g_last ? '0 : g_ff + IW'(1);
         end
         CMD_SRCH_A: a_ff <= rd;
         CMD_SRCH_B: begin
            spread_ff <= c_now;
            i_ff      <= '0;
            j_ff      <= '0;
         end
         CMD_PAIR_A: a_ff <= rd;
         CMD_PAIR_B: c_ff <= c_now;
         CMD_GRD_INIT: begin
            start_ff <= rd;
            bins_ff  <= CW'(1);
            k_ff     <= CW'(1);
            limit_ff <= LW'(c_ff) + LW'(tol_s);
         end
         CMD_GRD_SCAN: begin
            if (status.k_end) begin
               if (status.fits) spread_ff <= c_ff;
            end else begin
               if (over) begin
                  bins_ff  <= bins_ff + CW'(1);
                  start_ff <= rd;
               end
               k_ff <= k_ff + CW'(1);
            end
         end
         CMD_PAIR_NEXT: begin
            if (status.j_last) begin
               i_ff <= i_ff + IW'(1);
               j_ff <= i_ff + IW'(1);
            end else begin
               j_ff <= j_ff + IW'(1);
            end
         end
         CMD_ST_INIT: begin
            start_ff   <= rd;
            mask_ff    <= MAX_GROUPS'(1);
            ns_ff      <= CW'(1);
            k_ff       <= CW'(1);
            limit_ff   <= LW'(spread_ff) + LW'(tol_s);
         end
         CMD_ST_SCAN: begin
            if (!status.k_end) begin
               if (over) begin
                  mask_ff[k_idx] <= 1'b1;
                  ns_ff          <= ns_ff + CW'(1);
                  start_ff       <= rd;
               end
               k_ff <= k_ff + CW'(1);
            end
         end
         CMD_SPL_CHK: j_ff <= IW'(npos_ff - CW'(1));
         CMD_SPL_A:   a_ff <= rd;
         CMD_SPL_B: begin
            if (status.split_ok) begin
               mask_ff[j_ff] <= 1'b1;
               ns_ff         <= ns_ff + CW'(1);
            end else begin
               j_ff <= j_ff - IW'(1);
            end
         end
         CMD_CEN_INIT, CMD_WST_INIT: begin
            k_ff <= '0;
            b_ff <= '0;
         end
         CMD_CEN_SCAN: begin
            if (!status.k_end) begin
               if (is_start) lo_ff <= rd;
               if (blast) begin
                  center_ff[b_ff[IW-1:0]] <= cval;
                  b_ff <= b_ff + CW'(1);
               end
               k_ff <= k_ff + CW'(1);
            end
         end
         CMD_WST_SCAN: begin
            if (!status.k_end) begin
               if (VALUE_BITS'(wabs) > worst_ff) worst_ff <= VALUE_BITS'(wabs);
               gbin_ff[ord_ff[k_idx]] <= cur_b;
               b_ff <= cur_b;
               k_ff <= k_ff + CW'(1);
            end
         end
         CMD_EMIT: begin
            rsp_group_index        <= GIDX_W'(g_ff);
            rsp_unshifted          <= un_e;
            rsp_bin_index          <= un_e ? BIN_W'(ns_ff) : BIN_W'(gb_e);
            rsp_bin_log_center     <= un_e ? '0 : center_ff[gb_e[IW-1:0]];
            rsp_worst_log_mismatch <= worst_ff;
            rsp_bins_used          <= BIN_W'(ns_ff) + BIN_W'(npos_ff < n_ff);
            rsp_final_res          <= status.g_last;
            g_ff                   <= g_ff + IW'(1);
         end
         default: ;
      endcase
   end
endmodule

// ===== rtl/minmax_interval_binning.sv =====
// Min-max interval binning: loads one log value per beat, bins on the last beat.
// Load: one beat per cycle while idle. After last, with n loaded and p unflagged groups, the run
// ranks all n groups, searches the bin width over pairs of the p sorted values, sets up the bin
// starts, splits bins, then finds centres and mismatch, then gives n result beats.
// Results come one per cycle on rsp_valid and cannot be stalled; busy drops with the last.
// Synchronous reset clears the load count and sets bin_count to 1, tie_tolerance to 0.
module minmax_interval_binning #(
   parameter int MAX_GROUPS = 32,
   parameter int VALUE_BITS = 22
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [VALUE_BITS-1:0]      req_log_alpha,
   input  logic                              req_no_removal,
   input  logic                              req_last,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [mmib_pkg::TOL_W-1:0]        csr_wdata,
   output logic                              rsp_valid,
   output logic [mmib_pkg::GIDX_W-1:0]       rsp_group_index,
   output logic [mmib_pkg::BIN_W-1:0]        rsp_bin_index,
   output logic signed [VALUE_BITS-1:0]      rsp_bin_log_center,
   output logic                              rsp_unshifted,
   output logic [VALUE_BITS-1:0]             rsp_worst_log_mismatch,
   output logic [mmib_pkg::BIN_W-1:0]        rsp_bins_used,
   output logic                              rsp_final_res
);
   import mmib_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       acc;

   // accept a beat only while idle
   assign acc = start && !busy;

   mmib_ctrl u_ctrl (
      .clock(clock), .reset(reset), .acc(acc), .req_last(req_last),
      .status(status), .cmd(cmd), .busy(busy)
   );

   mmib_datapath #(.MAX_GROUPS(MAX_GROUPS), .VALUE_BITS(VALUE_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status), .acc(acc),
      .req_log_alpha(req_log_alpha), .req_no_removal(req_no_removal),
      .req_last(req_last), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .rsp_valid(rsp_valid),
      .rsp_group_index(rsp_group_index), .rsp_bin_index(rsp_bin_index),
      .rsp_bin_log_center(rsp_bin_log_center), .rsp_unshifted(rsp_unshifted),
      .rsp_worst_log_mismatch(rsp_worst_log_mismatch),
      .rsp_bins_used(rsp_bins_used), .rsp_final_res(rsp_final_res)
   );
endmodule
